// File: rtl/assert_macros.svh
// assertion macros used by the rtl top level to check its own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: rtl/udg_pkg.sv
// shared types, codes and the crc-8 byte update for the register datagram engine
package udg_pkg;

    // request codes on the input channel
    localparam logic [1:0] REQ_WRITE   = 2'd0;
    localparam logic [1:0] REQ_READ    = 2'd1;
    localparam logic [1:0] REQ_RX_BYTE = 2'd2;
    localparam logic [1:0] REQ_TIMEOUT = 2'd3;

    // read completion status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_SHORT    = 2'd1;
    localparam logic [1:0] ST_BAD_HDR  = 2'd2;
    localparam logic [1:0] ST_BAD_CRC  = 2'd3;

    // result kinds
    localparam logic OUT_TX_BYTE = 1'b0;
    localparam logic OUT_DONE    = 1'b1;

    // job kinds passed from front to back
    localparam logic [1:0] JOB_WRITE = 2'd0;
    localparam logic [1:0] JOB_READ  = 2'd1;
    localparam logic [1:0] JOB_DONE  = 2'd2;

    // datagram constants
    localparam logic [7:0] SYNC_BYTE  = 8'h05;
    localparam logic [7:0] CRC_POLY   = 8'h07;
    localparam logic [7:0] WRITE_FLAG = 8'h80;
    localparam logic [7:0] MASTER_ID  = 8'hFF;

    // job queue depth
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  node;
        logic [6:0]  reg_addr;
        logic [31:0] value;
        logic [1:0]  status;
    } job_t;

    // crc-8, data fed lsb first
    function automatic logic [7:0] crc_feed(input logic [7:0] crc_in,
                                            input logic [7:0] data);
        logic [7:0] c;
        c = crc_in;
        for (int k = 0; k < 8; k++)
        begin
            if (c[7] ^ data[k])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// File: rtl/udg_front.sv
// front end: accepts items, tracks the link phase and queues datagram and completion jobs
module udg_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [7:0]          cfg_wr_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          req_type,
    input  logic [6:0]          reg_addr,
    input  logic [31:0]         write_value,
    input  logic [7:0]          rx_byte,
    input  logic                q_full,
    output logic                q_push,
    output udg_pkg::job_t       q_job
);

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_WECHO = 2'd1;
    localparam logic [1:0] PH_RECHO = 2'd2;
    localparam logic [1:0] PH_RRESP = 2'd3;

    logic [7:0]  node_reg;
    logic [1:0]  phase_reg, phase_next;
    logic [3:0]  count_reg, count_next;
    logic [6:0]  pend_reg, pend_next;
    logic [7:0]  crc_reg, crc_next;
    logic [31:0] shift_reg, shift_next;
    logic        hdr_ok_reg, hdr_ok_next;
    logic        accept;
    logic [3:0]  count_inc;
    logic [1:0]  done_status;

    assign in_ready  = !q_full;
    assign accept    = in_valid && in_ready;
    assign count_inc = count_reg + 4'd1;

    // completion status at the final response byte, bad header wins
    always_comb
    begin
        if (!hdr_ok_reg)
        begin
            done_status = udg_pkg::ST_BAD_HDR;
        end
        else if (crc_reg != rx_byte)
        begin
            done_status = udg_pkg::ST_BAD_CRC;
        end
        else
        begin
            done_status = udg_pkg::ST_OK;
        end
    end

    // phase tracking and job generation
    always_comb
    begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        pend_next    = pend_reg;
        crc_next     = crc_reg;
        shift_next   = shift_reg;
        hdr_ok_next  = hdr_ok_reg;
        q_push       = 1'b0;
        q_job.kind   = udg_pkg::JOB_DONE;
        q_job.node   = node_reg;
        q_job.reg_addr = reg_addr;
        q_job.value  = 32'd0;
        q_job.status = udg_pkg::ST_OK;
        if (accept)
        begin
            unique case (req_type)
                udg_pkg::REQ_WRITE:
                begin
                    q_push      = 1'b1;
                    q_job.kind  = udg_pkg::JOB_WRITE;
                    q_job.value = write_value;
                    phase_next  = PH_WECHO;
                    count_next  = 4'd0;
                end
                udg_pkg::REQ_READ:
                begin
                    q_push     = 1'b1;
                    q_job.kind = udg_pkg::JOB_READ;
                    pend_next  = reg_addr;
                    phase_next = PH_RECHO;
                    count_next = 4'd0;
                end
                udg_pkg::REQ_TIMEOUT:
                begin
                    if (phase_reg == PH_RECHO || phase_reg == PH_RRESP)
                    begin
                        q_push       = 1'b1;
                        q_job.status = udg_pkg::ST_SHORT;
                    end
                    phase_next = PH_IDLE;
                    count_next = 4'd0;
                end
                default:
                begin
                    unique case (phase_reg)
                        PH_WECHO:
                        begin
                            // drop the eight echo bytes of a write
                            if (count_inc >= 4'd8)
                            begin
                                phase_next = PH_IDLE;
                                count_next = 4'd0;
                            end
                            else
                            begin
                                count_next = count_inc;
                            end
                        end
                        PH_RECHO:
                        begin
                            // skip the four echo bytes of a read
                            if (count_inc >= 4'd4)
                            begin
                                phase_next  = PH_RRESP;
                                count_next  = 4'd0;
                                crc_next    = 8'd0;
                                shift_next  = 32'd0;
                                hdr_ok_next = 1'b1;
                            end
                            else
                            begin
                                count_next = count_inc;
                            end
                        end
                        PH_RRESP:
                        begin
                            if (count_reg < 4'd7)
                            begin
                                if (count_reg == 4'd0 && rx_byte != udg_pkg::SYNC_BYTE)
                                begin
                                    hdr_ok_next = 1'b0;
                                end
                                if (count_reg == 4'd1 && rx_byte != udg_pkg::MASTER_ID)
                                begin
                                    hdr_ok_next = 1'b0;
                                end
                                if (count_reg == 4'd2 && rx_byte != {1'b0, pend_reg})
                                begin
                                    hdr_ok_next = 1'b0;
                                end
                                if (count_reg >= 4'd3)
                                begin
                                    shift_next = {shift_reg[23:0], rx_byte};
                                end
                                crc_next   = udg_pkg::crc_feed(crc_reg, rx_byte);
                                count_next = count_inc;
                            end
                            else
                            begin
                                // crc byte closes the response
                                q_push       = 1'b1;
                                q_job.status = done_status;
                                q_job.value  = (done_status == udg_pkg::ST_OK) ?
                                               shift_reg : 32'd0;
                                phase_next   = PH_IDLE;
                                count_next   = 4'd0;
                            end
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_reg   <= 8'd0;
            phase_reg  <= PH_IDLE;
            count_reg  <= 4'd0;
            pend_reg   <= 7'd0;
            crc_reg    <= 8'd0;
            shift_reg  <= 32'd0;
            hdr_ok_reg <= 1'b1;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                node_reg <= cfg_wr_data;
            end
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            pend_reg   <= pend_next;
            crc_reg    <= crc_next;
            shift_reg  <= shift_next;
            hdr_ok_reg <= hdr_ok_next;
        end
    end

endmodule

// File: rtl/udg_queue.sv
// short job queue between the front and back ends
module udg_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  udg_pkg::job_t       push_job,
    input  logic                pop,
    output udg_pkg::job_t       head_job,
    output logic                full,
    output logic                empty
);

    localparam int PTR_W = (udg_pkg::QUEUE_DEPTH > 1) ? $clog2(udg_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(udg_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(udg_pkg::QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(udg_pkg::QUEUE_DEPTH);

    udg_pkg::job_t      slot_reg [udg_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full     = (count_reg == CNT_FULL);
    assign empty    = (count_reg == '0);
    assign head_job = slot_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// File: rtl/udg_back.sv
// back end: expands queued jobs into transmit bytes and completions, one per cycle unless stalled
module udg_back (
    input  logic                clk,
    input  logic                rst_n,
    input  udg_pkg::job_t       head_job,
    input  logic                q_empty,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                out_kind,
    output logic [7:0]          tx_byte,
    output logic                last_byte,
    output logic [31:0]         read_value,
    output logic [1:0]          read_status
);

    udg_pkg::job_t job_reg;
    logic          busy_reg, busy_next;
    logic [2:0]    idx_reg, idx_next;
    logic [7:0]    crc_reg, crc_next;
    logic          out_valid_reg;
    logic          out_kind_reg;
    logic [7:0]    tx_byte_reg;
    logic          last_byte_reg;
    logic [31:0]   read_value_reg;
    logic [1:0]    read_status_reg;
    logic          advance;
    logic          emit;
    logic          cur_last;
    logic [7:0]    cur_byte;

    assign advance = !out_valid_reg || out_ready;
    assign emit    = busy_reg && advance;
    assign q_pop   = !q_empty && (!busy_reg || (emit && cur_last));

    // byte of the current datagram at the current index
    always_comb
    begin
        cur_byte = crc_reg;
        cur_last = 1'b1;
        unique case (job_reg.kind)
            udg_pkg::JOB_WRITE:
            begin
                cur_last = (idx_reg == 3'd7);
                case (idx_reg)
                    3'd0:    cur_byte = udg_pkg::SYNC_BYTE;
                    3'd1:    cur_byte = job_reg.node;
                    3'd2:    cur_byte = {1'b0, job_reg.reg_addr} | udg_pkg::WRITE_FLAG;
                    3'd3:    cur_byte = job_reg.value[31:24];
                    3'd4:    cur_byte = job_reg.value[23:16];
                    3'd5:    cur_byte = job_reg.value[15:8];
                    3'd6:    cur_byte = job_reg.value[7:0];
                    default: cur_byte = crc_reg;
                endcase
            end
            udg_pkg::JOB_READ:
            begin
                cur_last = (idx_reg == 3'd3);
                case (idx_reg)
                    3'd0:    cur_byte = udg_pkg::SYNC_BYTE;
                    3'd1:    cur_byte = job_reg.node;
                    3'd2:    cur_byte = {1'b0, job_reg.reg_addr};
                    default: cur_byte = crc_reg;
                endcase
            end
            default:
            begin
                cur_byte = 8'd0;
                cur_last = 1'b1;
            end
        endcase
    end

    // job sequencing
    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        crc_next  = crc_reg;
        if (q_pop)
        begin
            busy_next = 1'b1;
            idx_next  = 3'd0;
            crc_next  = 8'd0;
        end
        else if (emit)
        begin
            busy_next = !cur_last;
            idx_next  = idx_reg + 3'd1;
            crc_next  = udg_pkg::crc_feed(crc_reg, cur_byte);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= 3'd0;
            crc_reg       <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
            crc_reg  <= crc_next;
            if (advance)
            begin
                out_valid_reg <= busy_reg;
            end
        end
    end

    // job and output payload
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            job_reg <= head_job;
        end
        if (emit)
        begin
            if (job_reg.kind == udg_pkg::JOB_DONE)
            begin
                out_kind_reg    <= udg_pkg::OUT_DONE;
                tx_byte_reg     <= 8'd0;
                last_byte_reg   <= 1'b0;
                read_value_reg  <= job_reg.value;
                read_status_reg <= job_reg.status;
            end
            else
            begin
                out_kind_reg    <= udg_pkg::OUT_TX_BYTE;
                tx_byte_reg     <= cur_byte;
                last_byte_reg   <= cur_last;
                read_value_reg  <= 32'd0;
                read_status_reg <= udg_pkg::ST_OK;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_kind    = out_kind_reg;
    assign tx_byte     = tx_byte_reg;
    assign last_byte   = last_byte_reg;
    assign read_value  = read_value_reg;
    assign read_status = read_status_reg;

endmodule

// File: rtl/uart_register_datagram_engine_core.sv
// top level: single-wire uart register link master, front end, job queue and back end
// path: request to queue slot, then back end job register, then output register
// output: a write gives eight bytes, a read four; completions give one result each;
// the back end byte sequencer emits one byte per cycle unless the output stalls
// input is taken every cycle the two-entry job queue has room; echo bytes push no job
// reset: asynchronous active low, link idle, node address zero, queue and output empty
`include "assert_macros.svh"

module uart_register_datagram_engine_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [6:0]  reg_addr,
    input  logic [31:0] write_value,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        out_kind,
    output logic [7:0]  tx_byte,
    output logic        last_byte,
    output logic [31:0] read_value,
    output logic [1:0]  read_status
);

    udg_pkg::job_t push_job;
    udg_pkg::job_t head_job;
    logic          q_push;
    logic          q_pop;
    logic          q_full;
    logic          q_empty;

    // front end
    udg_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .reg_addr    (reg_addr),
        .write_value (write_value),
        .rx_byte     (rx_byte),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_job       (push_job)
    );

    // job queue
    udg_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .head_job (head_job),
        .full     (q_full),
        .empty    (q_empty)
    );

    // back end
    udg_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_job    (head_job),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_kind    (out_kind),
        .tx_byte     (tx_byte),
        .last_byte   (last_byte),
        .read_value  (read_value),
        .read_status (read_status)
    );

    // queue never overflows or underflows
    `ASSERT_IMPLIES(a_no_overflow, q_push, !q_full, "job pushed into a full queue")
    `ASSERT_IMPLIES(a_no_underflow, q_pop, !q_empty, "job popped from an empty queue")
    // completion carries no datagram byte
    `ASSERT_IMPLIES(a_done_clean, out_valid && out_kind, (tx_byte == 8'd0) && !last_byte,
                    "completion with transmit fields set")
    // transmit byte carries no read result
    `ASSERT_IMPLIES(a_tx_clean, out_valid && !out_kind,
                    (read_value == 32'd0) && (read_status == udg_pkg::ST_OK),
                    "transmit byte with read fields set")

endmodule
